// ===== src/cbf_pkg.sv =====
// Package for the cluster box filter: widths of the point, count and result fields,
// register indexes and their reset values.
// Used by cbf_mul and cluster_box_filter; depends on nothing.
package cbf_pkg;

   localparam int COORD_WIDTH = 12;
   localparam int COUNT_WIDTH = 24;

   localparam int FILL_LIMIT_WIDTH = 9;
   localparam int ASPECT_WIDTH     = 16;
   localparam int BOX_NUMBER_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = ASPECT_WIDTH;

   localparam int REQ_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH = BOX_NUMBER_WIDTH + 4 * COORD_WIDTH;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   localparam int MUL_A_WIDTH = 2 * COORD_WIDTH + 1;
   localparam int MUL_B_WIDTH = ASPECT_WIDTH;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int CMP_WIDTH   = (COUNT_WIDTH + 8 > PROD_WIDTH) ? COUNT_WIDTH + 8 : PROD_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILL_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ASPECT_LOW  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ASPECT_HIGH = 2'd2;

   localparam logic [FILL_LIMIT_WIDTH-1:0] FILL_LIMIT_RESET  = 9'd128;
   localparam logic [ASPECT_WIDTH-1:0]     ASPECT_LOW_RESET  = 16'd26;
   localparam logic [ASPECT_WIDTH-1:0]     ASPECT_HIGH_RESET = 16'd2560;

endpackage

// ===== src/cluster_box_filter.sv =====
// Cluster box filter top level: segment and cluster bounding boxes, fill and aspect
// tests on one shared multiplier, and a registered result. Depends on cbf_pkg, cbf_mul.
// A point without a segment end is taken in the idle state. A segment end keeps
// req_tready low through the area, fill-product and test states; a cluster end adds the
// low and high aspect-product states and the decision state, which registers the result
// once the result register is free; a held result stalls the decision step until taken.
// Synchronous active-high reset clears all boxes, the box count, the state and rsp_tvalid.
module cluster_box_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cbf_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,  // point_x, point_y
   input  logic                                 req_tuser,  // segment_end
   input  logic                                 req_tlast,  // cluster_end
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cbf_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,  // box_number, box_left,
                                                            // box_top, box_right, box_bottom
   output logic                                 rsp_tuser,  // keep
   input  logic                                 csr_we,
   input  logic [cbf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cbf_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import cbf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_AREA, S_FILL, S_TEST, S_LOW, S_HIGH, S_DEC
   } state_type;

   localparam logic [COORD_WIDTH-1:0] COORD_ONES = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;

   state_type state_ff, state_in;

   logic [FILL_LIMIT_WIDTH-1:0] fill_limit_ff;
   logic [ASPECT_WIDTH-1:0]     aspect_low_ff, aspect_high_ff;

   logic [COORD_WIDTH-1:0] seg_min_x_ff, seg_max_x_ff, seg_min_y_ff, seg_max_y_ff;
   logic [COORD_WIDTH-1:0] seg_min_x_in, seg_max_x_in, seg_min_y_in, seg_max_y_in;
   logic [COUNT_WIDTH-1:0] seg_points_ff, seg_points_in;
   logic [COORD_WIDTH-1:0] clu_min_x_ff, clu_max_x_ff, clu_min_y_ff, clu_max_y_ff;
   logic [COORD_WIDTH-1:0] clu_min_x_in, clu_max_x_in, clu_min_y_in, clu_max_y_in;
   logic                   fill_seen_ff, fill_seen_in;
   logic                   clu_end_ff, clu_end_in;
   logic                   above_ff, above_in;
   logic [BOX_NUMBER_WIDTH-1:0] boxes_ff, boxes_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_keep_ff, rsp_keep_in;
   logic [BOX_NUMBER_WIDTH-1:0] rsp_number_ff, rsp_number_in;
   logic [COORD_WIDTH-1:0]      rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;
   logic [COORD_WIDTH-1:0]      rsp_left_in, rsp_top_in, rsp_right_in, rsp_bottom_in;

   logic [COORD_WIDTH-1:0] point_x, point_y;
   logic                   req_accept;
   logic [COORD_WIDTH:0]   seg_height, seg_width;
   logic [COORD_WIDTH-1:0] clu_dx, clu_dy;
   logic [MUL_A_WIDTH-1:0] mul_a;
   logic [MUL_B_WIDTH-1:0] mul_b;
   logic [PROD_WIDTH-1:0]  product;
   logic [CMP_WIDTH-1:0]   count_scaled, dy_scaled, product_cmp;
   logic                   below, keep;

   assign point_x    = req_tdata[COORD_WIDTH-1:0];
   assign point_y    = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign seg_height = {1'b0, seg_max_y_ff} - {1'b0, seg_min_y_ff} + 1'b1;
   assign seg_width  = {1'b0, seg_max_x_ff} - {1'b0, seg_min_x_ff} + 1'b1;
   assign clu_dx     = clu_max_x_ff - clu_min_x_ff;
   assign clu_dy     = (clu_max_y_ff >= clu_min_y_ff) ? clu_max_y_ff - clu_min_y_ff : '0;

   assign count_scaled = CMP_WIDTH'({seg_points_ff, 8'd0});
   assign dy_scaled    = CMP_WIDTH'({clu_dy, 8'd0});
   assign product_cmp  = CMP_WIDTH'(product);
   assign below        = dy_scaled < product_cmp;
   assign keep         = fill_seen_ff && (clu_dx != '0) && above_ff && below;

   always_comb begin
      mul_a = MUL_A_WIDTH'(clu_dx);
      mul_b = aspect_low_ff;
      case (state_ff)
         S_AREA: begin
            mul_a = MUL_A_WIDTH'(seg_height);
            mul_b = MUL_B_WIDTH'(seg_width);
         end
         S_FILL: begin
            mul_a = product[MUL_A_WIDTH-1:0];
            mul_b = MUL_B_WIDTH'(fill_limit_ff);
         end
         S_HIGH, S_DEC: begin
            mul_b = aspect_high_ff;
         end
         default: begin
         end
      endcase
   end

   cbf_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (product)
   );

   always_comb begin
      state_in      = state_ff;
      seg_min_x_in  = seg_min_x_ff;
      seg_max_x_in  = seg_max_x_ff;
      seg_min_y_in  = seg_min_y_ff;
      seg_max_y_in  = seg_max_y_ff;
      seg_points_in = seg_points_ff;
      clu_min_x_in  = clu_min_x_ff;
      clu_max_x_in  = clu_max_x_ff;
      clu_min_y_in  = clu_min_y_ff;
      clu_max_y_in  = clu_max_y_ff;
      fill_seen_in  = fill_seen_ff;
      clu_end_in    = clu_end_ff;
      above_in      = above_ff;
      boxes_in      = boxes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_keep_in   = rsp_keep_ff;
      rsp_number_in = rsp_number_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_bottom_in = rsp_bottom_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (point_x < seg_min_x_ff) seg_min_x_in = point_x;
               if (point_x > seg_max_x_ff) seg_max_x_in = point_x;
               if (point_y < seg_min_y_ff) seg_min_y_in = point_y;
               if (point_y > seg_max_y_ff) seg_max_y_in = point_y;
               if (seg_points_ff != COUNT_MAX) seg_points_in = seg_points_ff + 1'b1;
               clu_end_in = req_tlast;
               if (req_tuser || req_tlast) state_in = S_AREA;
            end
         end
         S_AREA: begin
            state_in = S_FILL;
         end
         S_FILL: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            if ((count_scaled < product_cmp) && (seg_points_ff != '0)) fill_seen_in = 1'b1;
            if (seg_min_x_ff < clu_min_x_ff) clu_min_x_in = seg_min_x_ff;
            if (seg_max_x_ff > clu_max_x_ff) clu_max_x_in = seg_max_x_ff;
            if (seg_min_y_ff < clu_min_y_ff) clu_min_y_in = seg_min_y_ff;
            if (seg_max_y_ff > clu_max_y_ff) clu_max_y_in = seg_max_y_ff;
            seg_min_x_in  = COORD_ONES;
            seg_max_x_in  = '0;
            seg_min_y_in  = COORD_ONES;
            seg_max_y_in  = '0;
            seg_points_in = '0;
            state_in      = clu_end_ff ? S_LOW : S_IDLE;
         end
         S_LOW: begin
            state_in = S_HIGH;
         end
         S_HIGH: begin
            above_in = dy_scaled > product_cmp;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_keep_in   = keep;
               rsp_number_in = keep ? boxes_ff : '0;
               rsp_left_in   = clu_min_x_ff;
               rsp_top_in    = clu_min_y_ff;
               rsp_right_in  = clu_max_x_ff;
               rsp_bottom_in = clu_max_y_ff;
               if (keep) boxes_in = boxes_ff + 1'b1;
               clu_min_x_in  = COORD_ONES;
               clu_max_x_in  = '0;
               clu_min_y_in  = COORD_ONES;
               clu_max_y_in  = '0;
               fill_seen_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fill_limit_ff  <= FILL_LIMIT_RESET;
         aspect_low_ff  <= ASPECT_LOW_RESET;
         aspect_high_ff <= ASPECT_HIGH_RESET;
         seg_min_x_ff   <= COORD_ONES;
         seg_max_x_ff   <= '0;
         seg_min_y_ff   <= COORD_ONES;
         seg_max_y_ff   <= '0;
         seg_points_ff  <= '0;
         clu_min_x_ff   <= COORD_ONES;
         clu_max_x_ff   <= '0;
         clu_min_y_ff   <= COORD_ONES;
         clu_max_y_ff   <= '0;
         fill_seen_ff   <= 1'b0;
         clu_end_ff     <= 1'b0;
         above_ff       <= 1'b0;
         boxes_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seg_min_x_ff  <= seg_min_x_in;
         seg_max_x_ff  <= seg_max_x_in;
         seg_min_y_ff  <= seg_min_y_in;
         seg_max_y_ff  <= seg_max_y_in;
         seg_points_ff <= seg_points_in;
         clu_min_x_ff  <= clu_min_x_in;
         clu_max_x_ff  <= clu_max_x_in;
         clu_min_y_ff  <= clu_min_y_in;
         clu_max_y_ff  <= clu_max_y_in;
         fill_seen_ff  <= fill_seen_in;
         clu_end_ff    <= clu_end_in;
         above_ff      <= above_in;
         boxes_ff      <= boxes_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FILL_LIMIT:  fill_limit_ff  <= csr_wdata[FILL_LIMIT_WIDTH-1:0];
               CSR_ASPECT_LOW:  aspect_low_ff  <= csr_wdata[ASPECT_WIDTH-1:0];
               CSR_ASPECT_HIGH: aspect_high_ff <= csr_wdata[ASPECT_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
      rsp_keep_ff   <= rsp_keep_in;
      rsp_number_ff <= rsp_number_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_bottom_ff <= rsp_bottom_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_keep_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_bottom_ff, rsp_right_ff, rsp_top_ff,
                                        rsp_left_ff, rsp_number_ff});

   a_seg_end_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser || req_tlast)) |=> !req_tready)
      else $error("Input accepted during segment-end processing.");

   a_discard_number_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_keep_ff) |-> (rsp_number_ff == '0))
      else $error("Discarded cluster carries a nonzero box number.");

   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_left_ff <= rsp_right_ff) && (rsp_top_ff <= rsp_bottom_ff)))
      else $error("Result box has inverted corners.");

   a_segment_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST) |=> ((seg_points_ff == '0) && (seg_max_x_ff == '0)))
      else $error("Segment state not cleared after the fill test.");

   a_box_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DEC) |=> $stable(boxes_ff))
      else $error("Box count changed outside the decision step.");

endmodule

// ===== src/cbf_mul.sv =====
// Shared unsigned multiplier with a registered product, used by the sequencer
// of cluster_box_filter for the area, fill and aspect products. Depends on cbf_pkg.
module cbf_mul (
   input  logic                           clock,
   input  logic [cbf_pkg::MUL_A_WIDTH-1:0] a,
   input  logic [cbf_pkg::MUL_B_WIDTH-1:0] b,
   output logic [cbf_pkg::PROD_WIDTH-1:0]  product
);
   import cbf_pkg::*;

   logic [PROD_WIDTH-1:0] product_ff;
   logic [PROD_WIDTH-1:0] product_in;

   assign product_in = PROD_WIDTH'(a) * PROD_WIDTH'(b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule
